// ===== hw/rtl/slfr_pkg.sv =====
package slfr_pkg;

   localparam int MAX_PAYLOAD  = 32;
   localparam int NUM_CHANNELS = 2;

   localparam int CH_W     = 1;                          // fixed by the channel field
   localparam int IDX_W    = $clog2(MAX_PAYLOAD);
   localparam int CNT_W    = $clog2(MAX_PAYLOAD + 1);
   localparam int ADDR_W   = CH_W + IDX_W;
   localparam int DEPTH    = NUM_CHANNELS * MAX_PAYLOAD;
   localparam int BYTE_W   = 8;
   localparam int NUM_SYNC = 4;
   localparam int CSR_IDX_W = 2;
   localparam int OUT_IDX_W = 5;
   localparam int OUT_LEN_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_THIRD  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FOURTH = 2'd3;

   localparam logic REQ_BYTE    = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      HUNT_IDLE    = 3'd0,
      HUNT_SYNC1   = 3'd1,
      HUNT_SYNC2   = 3'd2,
      HUNT_SYNC3   = 3'd3,
      HUNT_LEN     = 3'd4,
      HUNT_DATA    = 3'd5,
      HUNT_DISCARD = 3'd6
   } hunt_state_type;

   typedef enum logic [1:0] {
      CTL_IDLE = 2'd0,
      CTL_READ = 2'd1,
      CTL_SHOW = 2'd2
   } ctl_state_type;

   typedef struct packed {
      logic accept;
      logic idx_clr;
      logic idx_inc;
      logic rd_en;
   } cmd_type;

   typedef struct packed {
      logic frame_done;
      logic last;
   } status_type;

endpackage

// ===== hw/rtl/slfr_ctrl.sv =====
module slfr_ctrl
   import slfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         CTL_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && status.frame_done) begin
               cmd.idx_clr = 1'b1;
               state_in    = CTL_READ;
            end
         end
         CTL_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = CTL_SHOW;
         end
         CTL_SHOW: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (status.last) begin
                  state_in = CTL_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = CTL_READ;
               end
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/slfr_datapath.sv =====
module slfr_datapath
   import slfr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic                 req_type,
   input  logic [CH_W-1:0]      req_channel,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data,
   output logic [CH_W-1:0]      rsp_out_channel,
   output logic [BYTE_W-1:0]    rsp_out_byte,
   output logic [OUT_IDX_W-1:0] rsp_out_index,
   output logic [OUT_LEN_W-1:0] rsp_out_length,
   output logic                 rsp_out_last
);

   logic [BYTE_W-1:0] sync_ff [NUM_SYNC];

   hunt_state_type    hunt_ff  [NUM_CHANNELS];
   logic [CNT_W-1:0]  cnt_ff   [NUM_CHANNELS];
   logic [CNT_W-1:0]  len_ff   [NUM_CHANNELS];
   logic              drop_ff  [NUM_CHANNELS];
   logic              ready_ff [NUM_CHANNELS];

   hunt_state_type    hunt_in;
   logic [CNT_W-1:0]  cnt_in, len_in, cnt_inc;
   logic              drop_in, ready_in, wr_en, done;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_ff;
   logic [CH_W-1:0]   emit_ch_ff;
   logic [CNT_W-1:0]  emit_len_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [CNT_W-1:0]  idx_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff[0] <= 8'd1;
         sync_ff[1] <= 8'd2;
         sync_ff[2] <= 8'd3;
         sync_ff[3] <= 8'd4;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SYNC_FIRST:  sync_ff[0] <= csr_data;
            CSR_SYNC_SECOND: sync_ff[1] <= csr_data;
            CSR_SYNC_THIRD:  sync_ff[2] <= csr_data;
            CSR_SYNC_FOURTH: sync_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // next state of the addressed channel
   always_comb begin
      hunt_in  = hunt_ff[req_channel];
      cnt_in   = cnt_ff[req_channel];
      len_in   = len_ff[req_channel];
      drop_in  = drop_ff[req_channel];
      ready_in = ready_ff[req_channel];
      cnt_inc  = cnt_ff[req_channel] + CNT_W'(1);
      wr_en    = 1'b0;
      done     = 1'b0;
      if (req_type == REQ_RELEASE) begin
         ready_in = 1'b0;
      end else if (!ready_ff[req_channel]) begin
         case (hunt_ff[req_channel])
            HUNT_SYNC1, HUNT_SYNC2, HUNT_SYNC3: begin
               if (req_rx_byte == sync_ff[hunt_ff[req_channel][1:0]]) begin
                  hunt_in = hunt_state_type'(hunt_ff[req_channel] + 3'd1);
               end else begin
                  drop_in = 1'b1;
                  hunt_in = HUNT_DISCARD;
               end
            end
            HUNT_LEN: begin
               if (req_rx_byte == '0 || req_rx_byte > BYTE_W'(MAX_PAYLOAD)) begin
                  hunt_in = HUNT_IDLE;
               end else begin
                  len_in  = req_rx_byte[CNT_W-1:0];
                  cnt_in  = '0;
                  hunt_in = HUNT_DATA;
               end
            end
            HUNT_DATA: begin
               wr_en  = !drop_ff[req_channel];
               cnt_in = cnt_inc;
               if (cnt_inc >= len_ff[req_channel]) begin
                  if (drop_ff[req_channel]) begin
                     drop_in = 1'b0;
                  end else begin
                     ready_in = 1'b1;
                     done     = 1'b1;
                  end
                  cnt_in  = '0;
                  hunt_in = HUNT_IDLE;
               end
            end
            HUNT_DISCARD: begin
               drop_in = 1'b0;
               cnt_in  = '0;
               hunt_in = HUNT_IDLE;
            end
            default: begin
               hunt_in = (req_rx_byte == sync_ff[0]) ? HUNT_SYNC1 : HUNT_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            hunt_ff[i]  <= HUNT_IDLE;
            cnt_ff[i]   <= '0;
            len_ff[i]   <= '0;
            drop_ff[i]  <= 1'b0;
            ready_ff[i] <= 1'b0;
         end
      end else if (cmd.accept) begin
         hunt_ff[req_channel]  <= hunt_in;
         cnt_ff[req_channel]   <= cnt_in;
         len_ff[req_channel]   <= len_in;
         drop_ff[req_channel]  <= drop_in;
         ready_ff[req_channel] <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && wr_en) begin
         mem[{req_channel, cnt_ff[req_channel][IDX_W-1:0]}] <= req_rx_byte;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[{emit_ch_ff, idx_ff}];
      end
   end

   assign idx_next = {1'b0, idx_ff} + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.idx_clr) begin
         idx_ff      <= '0;
         emit_ch_ff  <= req_channel;
         emit_len_ff <= len_ff[req_channel];
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_next[IDX_W-1:0];
      end
   end

   assign status.frame_done = done;
   assign status.last       = (idx_next == emit_len_ff);

   assign rsp_out_channel = emit_ch_ff;
   assign rsp_out_byte    = rd_ff;
   assign rsp_out_index   = OUT_IDX_W'(idx_ff);
   assign rsp_out_length  = OUT_LEN_W'(emit_len_ff);
   assign rsp_out_last    = status.last;

endmodule

// ===== hw/rtl/sync_length_frame_receiver_unit.sv =====
// A byte that completes a frame is taken while the controller is idle; its results then
// appear one byte at a time, each through a memory read state and then a show state.
// Throughput: one input item per cycle while idle; while a frame of length N is read out,
// input stalls until its last byte is shown (longer if the result side stalls).
// Reset (synchronous, active high) clears every channel to hunting and the sync bytes
// to 1, 2, 3, 4; the payload memory is not cleared.
module sync_length_frame_receiver_unit
   import slfr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_type,
   input  logic [CH_W-1:0]      req_channel,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CH_W-1:0]      rsp_out_channel,
   output logic [BYTE_W-1:0]    rsp_out_byte,
   output logic [OUT_IDX_W-1:0] rsp_out_index,
   output logic [OUT_LEN_W-1:0] rsp_out_length,
   output logic                 rsp_out_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   slfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   slfr_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_type        (req_type),
      .req_channel     (req_channel),
      .req_rx_byte     (req_rx_byte),
      .csr_valid       (csr_valid & csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_out_channel (rsp_out_channel),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_index   (rsp_out_index),
      .rsp_out_length  (rsp_out_length),
      .rsp_out_last    (rsp_out_last)
   );

   // no input transfer while a frame is being read out
   a_no_input_during_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted during frame readout");

   a_index_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_out_index} < rsp_out_length))
      else $error("payload index beyond frame length");

   a_resume_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_out_last) |=> !req_stall)
      else $error("input not resumed after final payload byte");

   a_next_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_out_last) |=> ##1
         (rsp_valid && rsp_out_index == $past(rsp_out_index, 2) + 5'd1))
      else $error("payload index did not advance by one");

endmodule

// ===== verif/tb_top.sv =====
module tb_top
   import slfr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STUCK_LIMIT  = 2000;
   localparam int SETTLE_WAIT  = 8;
   localparam int PHASE_ITEMS  = 70;
   localparam int NUM_PHASES   = 4;
   localparam int QUIET_PHASE  = 2;
   localparam int IDLE_PERCENT = 17;

   typedef struct packed {
      logic                 rtype;
      logic [CH_W-1:0]      ch;
      logic [BYTE_W-1:0]    data;
   } rx_item_type;

   typedef struct packed {
      logic [CH_W-1:0]      ch;
      logic [BYTE_W-1:0]    data;
      logic [OUT_IDX_W-1:0] idx;
      logic [OUT_LEN_W-1:0] len;
      logic                 last;
   } frame_beat_type;

   localparam logic [CSR_IDX_W-1:0] SYNC_REGS [NUM_SYNC] =
      '{CSR_SYNC_FIRST, CSR_SYNC_SECOND, CSR_SYNC_THIRD, CSR_SYNC_FOURTH};

   // runs against the reset sync bytes 1, 2, 3, 4
   localparam rx_item_type DIRECTED [27] = '{
      {REQ_BYTE, 1'b0, 8'h01}, {REQ_BYTE, 1'b0, 8'h02}, {REQ_BYTE, 1'b0, 8'h03},
      {REQ_BYTE, 1'b0, 8'h04}, {REQ_BYTE, 1'b0, 8'h01}, {REQ_BYTE, 1'b0, 8'hFF},
      {REQ_BYTE, 1'b0, 8'h00},                          // held frame: ignored
      {REQ_RELEASE, 1'b0, 8'h00},
      {REQ_RELEASE, 1'b1, 8'hFF},                       // nothing held
      {REQ_BYTE, 1'b1, 8'h01}, {REQ_BYTE, 1'b1, 8'h07}, // bad second sync
      {REQ_BYTE, 1'b1, 8'h01},                          // dropped
      {REQ_BYTE, 1'b1, 8'h01}, {REQ_BYTE, 1'b1, 8'h02}, {REQ_BYTE, 1'b1, 8'h03},
      {REQ_BYTE, 1'b1, 8'h09},                          // bad fourth sync
      {REQ_BYTE, 1'b1, 8'h55},
      {REQ_BYTE, 1'b0, 8'h01}, {REQ_BYTE, 1'b0, 8'h02}, {REQ_BYTE, 1'b0, 8'h03},
      {REQ_BYTE, 1'b0, 8'h04}, {REQ_BYTE, 1'b0, 8'h00}, // zero length
      {REQ_BYTE, 1'b1, 8'h01}, {REQ_BYTE, 1'b1, 8'h02}, {REQ_BYTE, 1'b1, 8'h03},
      {REQ_BYTE, 1'b1, 8'h04}, {REQ_BYTE, 1'b1, 8'hFF}  // oversize length
   };

   class frame_scoreboard;
      logic [BYTE_W-1:0] sync_cfg [NUM_SYNC];
      hunt_state_type    hunt  [NUM_CHANNELS];
      logic [5:0]        count [NUM_CHANNELS];
      logic [7:0]        flen  [NUM_CHANNELS];
      logic              drop  [NUM_CHANNELS];
      logic              ready [NUM_CHANNELS];
      logic [7:0]        store [NUM_CHANNELS][MAX_PAYLOAD];
      frame_beat_type    beats_due [$];
      int                errors;

      function new();
         sync_cfg = '{8'd1, 8'd2, 8'd3, 8'd4};
         foreach (hunt[i]) begin
            hunt[i]  = HUNT_IDLE;
            count[i] = '0;
            flen[i]  = '0;
            drop[i]  = 1'b0;
            ready[i] = 1'b0;
         end
         errors = 0;
      endfunction

      function void write_sync(logic [CSR_IDX_W-1:0] idx, logic [BYTE_W-1:0] v);
         sync_cfg[idx] = v;
      endfunction

      function void take_request(logic rtype, logic [CH_W-1:0] ch, logic [BYTE_W-1:0] b);
         hunt_state_type st;
         int unsigned    c;
         if (rtype == REQ_RELEASE) begin
            ready[ch] = 1'b0;
            return;
         end
         if (ready[ch])
            return;
         st = hunt[ch];
         case (st)
            HUNT_SYNC1, HUNT_SYNC2, HUNT_SYNC3: begin
               if (b == sync_cfg[st]) begin
                  st = hunt_state_type'(st + 1);
               end else begin
                  drop[ch] = 1'b1;
                  st = HUNT_DISCARD;
               end
            end
            HUNT_LEN: begin
               if (b == 0 || b > MAX_PAYLOAD) begin
                  st = HUNT_IDLE;
               end else begin
                  flen[ch]  = b;
                  count[ch] = '0;
                  st = HUNT_DATA;
               end
            end
            HUNT_DATA: begin
               c = count[ch];
               if (!drop[ch] && c < MAX_PAYLOAD)
                  store[ch][c] = b;
               c++;
               count[ch] = 6'(c);
               if (c >= flen[ch]) begin
                  if (drop[ch]) begin
                     drop[ch] = 1'b0;
                  end else begin
                     ready[ch] = 1'b1;
                     for (int k = 0; k < flen[ch] && k < MAX_PAYLOAD; k++)
                        beats_due.push_back({ch, store[ch][k], OUT_IDX_W'(k),
                                             OUT_LEN_W'(flen[ch]), k + 1 == flen[ch]});
                  end
                  count[ch] = '0;
                  st = HUNT_IDLE;
               end
            end
            HUNT_DISCARD: begin
               drop[ch]  = 1'b0;
               count[ch] = '0;
               st = HUNT_IDLE;
            end
            default: st = (b == sync_cfg[0]) ? HUNT_SYNC1 : HUNT_IDLE;
         endcase
         hunt[ch] = st;
      endfunction

      function void compare(string what, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            errors++;
         end
      endfunction

      function void check_beat(frame_beat_type got);
         frame_beat_type want;
         if (beats_due.size() == 0) begin
            $display("%0t: unexpected result ch=%0d byte=%02h idx=%0d len=%0d last=%0b",
                     $time, got.ch, got.data, got.idx, got.len, got.last);
            errors++;
            return;
         end
         want = beats_due.pop_front();
         compare("out_channel", want.ch, got.ch);
         compare("out_byte", want.data, got.data);
         compare("out_index", want.idx, got.idx);
         compare("out_length", want.len, got.len);
         compare("out_last", want.last, got.last);
      endfunction

      function void close_out();
         if (beats_due.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, beats_due.size());
            errors += beats_due.size();
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   logic                 req_type    = REQ_BYTE;
   logic [CH_W-1:0]      req_channel = '0;
   logic [BYTE_W-1:0]    req_rx_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   logic [CH_W-1:0]      rsp_out_channel;
   logic [BYTE_W-1:0]    rsp_out_byte;
   logic [OUT_IDX_W-1:0] rsp_out_index;
   logic [OUT_LEN_W-1:0] rsp_out_length;
   logic                 rsp_out_last;
   logic                 csr_valid   = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index   = CSR_SYNC_FIRST;
   logic [BYTE_W-1:0]    csr_data    = '0;

   logic                 quiet = 1'b0;
   int unsigned          stuck = 0;
   frame_scoreboard      board = new();
   rx_item_type          plan [NUM_CHANNELS][$];

   sync_length_frame_receiver_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock)
      rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         board.check_beat({rsp_out_channel, rsp_out_byte, rsp_out_index,
                           rsp_out_length, rsp_out_last});

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         stuck <= 0;
      end else if (stuck == STUCK_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         stuck <= stuck + 1;
      end
   end

   task automatic send_item(rx_item_type it);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= it.rtype;
      req_channel <= it.ch;
      req_rx_byte <= it.data;
      do @(posedge clock); while (req_stall);
      board.take_request(it.rtype, it.ch, it.data);
   endtask

   task automatic hold_requests();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic settle();
      while (board.beats_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [BYTE_W-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      board.write_sync(idx, v);
   endtask

   function automatic void push(int ch, logic rtype, logic [BYTE_W-1:0] b);
      plan[ch].push_back({rtype, CH_W'(ch), b});
   endfunction

   // mostly well-formed frames; the rest bad lengths, broken syncs, lone releases and noise
   function automatic void plan_sequence(int ch);
      int unsigned r;
      int unsigned len;
      int unsigned p;
      r = $urandom_range(99);
      if (r < 80) begin
         for (int i = 0; i < NUM_SYNC; i++)
            push(ch, REQ_BYTE, board.sync_cfg[i]);
         if (r < 70) begin
            p = $urandom_range(9);
            len = (p == 0) ? MAX_PAYLOAD :
                  (p == 1) ? $urandom_range(MAX_PAYLOAD - 1, 9) : $urandom_range(8, 1);
            push(ch, REQ_BYTE, BYTE_W'(len));
            repeat (len) push(ch, REQ_BYTE, BYTE_W'($urandom_range(255)));
            if ($urandom_range(4) == 0)
               push(ch, REQ_BYTE, BYTE_W'($urandom_range(255)));
            push(ch, REQ_RELEASE, BYTE_W'($urandom_range(255)));
         end else begin
            push(ch, REQ_BYTE, ($urandom_range(3) == 0) ? BYTE_W'(0) :
                               BYTE_W'($urandom_range(255, MAX_PAYLOAD + 1)));
         end
      end else if (r < 90) begin
         p = $urandom_range(NUM_SYNC - 1, 1);
         for (int i = 0; i < p; i++)
            push(ch, REQ_BYTE, board.sync_cfg[i]);
         push(ch, REQ_BYTE, board.sync_cfg[p] ^ 8'($urandom_range(255, 1)));
         push(ch, REQ_BYTE, BYTE_W'($urandom_range(255)));
      end else if ($urandom_range(1) == 0) begin
         push(ch, REQ_RELEASE, BYTE_W'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(3, 1)) push(ch, REQ_BYTE, BYTE_W'($urandom_range(255)));
      end
   endfunction

   task automatic run_traffic(int unsigned n);
      int unsigned sent;
      int          ch;
      sent = 0;
      while (sent < n || plan[0].size() + plan[1].size() != 0) begin
         if (sent < n)
            for (int c = 0; c < NUM_CHANNELS; c++)
               if (plan[c].size() == 0)
                  plan_sequence(c);
         do ch = $urandom_range(NUM_CHANNELS - 1); while (plan[ch].size() == 0);
         send_item(plan[ch].pop_front());
         sent++;
      end
   endtask

   initial begin
      logic [BYTE_W-1:0] v;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i])
         send_item(DIRECTED[i]);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         // registers change only once every transfer of the last phase is out
         hold_requests();
         settle();
         quiet = (phase == QUIET_PHASE);
         for (int i = 0; i < NUM_SYNC; i++) begin
            case (phase)
               0:       v = 8'h00;
               1:       v = 8'hFF;
               default: v = BYTE_W'($urandom_range(255));
            endcase
            write_reg(SYNC_REGS[i], v);
         end
         @(negedge clock);
         csr_valid <= 1'b0;
         run_traffic(PHASE_ITEMS);
      end

      hold_requests();
      settle();
      board.close_out();
      if (board.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
